FILE: sv/h265_rtp_depacketizer_defines.svh
// Assertion macros shared by the depacketizer checker.
`ifndef H265_RTP_DEPACKETIZER_DEFINES_SVH
`define H265_RTP_DEPACKETIZER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define HRD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low
`define HRD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/hrd_pkg.sv
// Shared types and constants of the H.265 RTP depacketizer.
package hrd_pkg;

	// Width of the packet length that is used
	localparam int LenBits = 16;

	// Longest run of result words caused by one input word
	localparam int RunMax = 7;
	localparam int CntW   = $clog2(RunMax + 1);

	// NAL unit types of RTP payload structures
	localparam logic [5:0] NalTypeAp = 6'd48;
	localparam logic [5:0] NalTypeFu = 6'd49;

	// FU header bits and NAL header rebuild masks
	localparam logic [7:0] NalHdrKeep = 8'h81;
	localparam logic [7:0] FuTypeMask = 8'h3F;
	localparam int         FuStartBit = 7;
	localparam int         FuEndBit   = 6;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       frame_end;
		logic       length_error;
		logic       last_of_run;
	} result_t;

	typedef struct packed {
		result_t [RunMax-1:0] ent;
		logic [CntW-1:0]      cnt;
	} run_t;

endpackage

FILE: sv/hrd_parse.sv
// Packet parser: tracks payload structure and builds the run of result words per byte.
module hrd_parse (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  logic [7:0]           data_byte,
	input  logic                 first_of_packet,
	input  logic [15:0]          packet_length,
	output hrd_pkg::run_t        run
);

	localparam logic [2:0] MODE_IDLE       = 3'd0;
	localparam logic [2:0] MODE_SINGLE     = 3'd1;
	localparam logic [2:0] MODE_FU_HEAD    = 3'd2;
	localparam logic [2:0] MODE_FU_DATA    = 3'd3;
	localparam logic [2:0] MODE_AP_SKIP    = 3'd4;
	localparam logic [2:0] MODE_AP_SIZE_HI = 3'd5;
	localparam logic [2:0] MODE_AP_SIZE_LO = 3'd6;
	localparam logic [2:0] MODE_AP_DATA    = 3'd7;

	localparam int NCand = 8;
	localparam int NW    = $clog2(NCand + 1);

	logic [2:0]                   mode_q, mode_n;
	logic [hrd_pkg::LenBits-1:0]  off_q, off_n;
	logic [hrd_pkg::LenBits-1:0]  rem_q, rem_n;
	logic [7:0]                   h0_q, h0_n;
	logic [7:0]                   h1_q, h1_n;
	logic [15:0]                  nsl_q, nsl_n;
	logic [7:0]                   shb_q, shb_n;

	logic [hrd_pkg::LenBits-1:0]  len;
	logic [15:0]                  ap_size;
	logic [hrd_pkg::LenBits-1:0]  ap_after;
	logic                         tail;
	logic                         sc_en, d0_en, d1_en, mk_en, mk_err, fin_en;
	logic [7:0]                   d0_b, d1_b;
	hrd_pkg::result_t [NCand-1:0] cand;
	logic [NCand-1:0]             cand_en;
	logic [NW-1:0]                n;

	assign len      = packet_length[hrd_pkg::LenBits-1:0];
	assign ap_size  = {shb_q, data_byte};
	assign ap_after = rem_q - hrd_pkg::LenBits'(1);

	// Decode one byte: next state and which result words it causes
	always_comb begin
		mode_n = mode_q;
		off_n  = off_q;
		rem_n  = rem_q;
		h0_n   = h0_q;
		h1_n   = h1_q;
		nsl_n  = nsl_q;
		shb_n  = shb_q;
		tail   = 1'b0;
		sc_en  = 1'b0;
		d0_en  = 1'b0;
		d0_b   = data_byte;
		d1_en  = 1'b0;
		d1_b   = h1_q;
		mk_en  = 1'b0;
		mk_err = 1'b0;
		fin_en = 1'b0;
		if (first_of_packet) begin
			mode_n = MODE_IDLE;
			off_n  = '0;
			rem_n  = len;
			if (len != '0) begin
				tail = 1'b1;
				if (data_byte[6:1] == hrd_pkg::NalTypeAp) begin
					mode_n = MODE_AP_SKIP;
				end else if (data_byte[6:1] == hrd_pkg::NalTypeFu) begin
					h0_n   = data_byte;
					mode_n = (len >= hrd_pkg::LenBits'(3)) ? MODE_FU_HEAD : MODE_IDLE;
				end else begin
					sc_en  = 1'b1;
					d0_en  = 1'b1;
					mode_n = MODE_SINGLE;
				end
			end
		end else if (mode_q != MODE_IDLE && rem_q != '0) begin
			tail  = 1'b1;
			off_n = off_q + hrd_pkg::LenBits'(1);
			unique case (mode_q)
				MODE_IDLE: begin
				end
				MODE_SINGLE, MODE_FU_DATA: begin
					d0_en = 1'b1;
				end
				MODE_FU_HEAD: begin
					if (off_n == hrd_pkg::LenBits'(1)) begin
						h1_n = data_byte;
					end else begin
						if (data_byte[hrd_pkg::FuStartBit]) begin
							sc_en = 1'b1;
							d0_en = 1'b1;
							d0_b  = (h0_q & hrd_pkg::NalHdrKeep)
								| {(data_byte[6:0] & hrd_pkg::FuTypeMask[6:0]), 1'b0};
							d1_en = 1'b1;
						end
						h1_n   = data_byte;
						mode_n = MODE_FU_DATA;
					end
				end
				MODE_AP_SKIP: begin
					mode_n = MODE_AP_SIZE_HI;
				end
				MODE_AP_SIZE_HI: begin
					if (rem_q <= hrd_pkg::LenBits'(3)) begin
						mode_n = MODE_IDLE;
					end else begin
						shb_n  = data_byte;
						mode_n = MODE_AP_SIZE_LO;
					end
				end
				MODE_AP_SIZE_LO: begin
					if (ap_size > 16'(ap_after)) begin
						mk_en  = 1'b1;
						mk_err = 1'b1;
						mode_n = MODE_IDLE;
					end else begin
						sc_en = 1'b1;
						if (ap_size == '0) begin
							mk_en  = 1'b1;
							mode_n = MODE_AP_SIZE_HI;
						end else begin
							nsl_n  = ap_size;
							mode_n = MODE_AP_DATA;
						end
					end
				end
				MODE_AP_DATA: begin
					d0_en = 1'b1;
					nsl_n = nsl_q - 16'd1;
					if (nsl_n == '0) begin
						mk_en  = 1'b1;
						mode_n = MODE_AP_SIZE_HI;
					end
				end
			endcase
		end
		// Count down the packet; close it when the last byte is used
		if (tail) begin
			if (rem_n != '0) begin
				rem_n = rem_n - hrd_pkg::LenBits'(1);
			end
			if (rem_n == '0) begin
				fin_en = (mode_n == MODE_SINGLE) || (mode_n == MODE_FU_DATA && h1_n[hrd_pkg::FuEndBit]);
				mode_n = MODE_IDLE;
			end
		end
	end

	// Candidate words in stream order: start code, header or data, marker, frame close
	always_comb begin
		cand[0] = '{out_byte: 8'h00, byte_valid: 1'b1, frame_end: 1'b0,
			length_error: 1'b0, last_of_run: 1'b0};
		cand[1] = cand[0];
		cand[2] = cand[0];
		cand[3] = '{out_byte: 8'h01, byte_valid: 1'b1, frame_end: 1'b0,
			length_error: 1'b0, last_of_run: 1'b0};
		cand[4] = '{out_byte: d0_b, byte_valid: 1'b1, frame_end: 1'b0,
			length_error: 1'b0, last_of_run: 1'b0};
		cand[5] = '{out_byte: d1_b, byte_valid: 1'b1, frame_end: 1'b0,
			length_error: 1'b0, last_of_run: 1'b0};
		cand[6] = '{out_byte: 8'h00, byte_valid: 1'b0, frame_end: !mk_err,
			length_error: mk_err, last_of_run: 1'b0};
		cand[7] = '{out_byte: 8'h00, byte_valid: 1'b0, frame_end: 1'b1,
			length_error: 1'b0, last_of_run: 1'b0};
		cand_en = {fin_en, mk_en, d1_en, d0_en, {4{sc_en}}};
	end

	// Pack the enabled words into the run and flag its last word
	always_comb begin
		run = '0;
		n   = '0;
		for (int i = 0; i < NCand; i++) begin
			if (cand_en[i]) begin
				if (n < NW'(hrd_pkg::RunMax)) begin
					run.ent[n[hrd_pkg::CntW-1:0]] = cand[i];
				end
				n = n + NW'(1);
			end
		end
		for (int i = 0; i < hrd_pkg::RunMax; i++) begin
			run.ent[i].last_of_run = (NW'(i) + NW'(1) == n);
		end
		run.cnt = (n > NW'(hrd_pkg::RunMax)) ? hrd_pkg::CntW'(hrd_pkg::RunMax)
			: n[hrd_pkg::CntW-1:0];
	end

	// Advance parser state on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			off_q  <= '0;
			rem_q  <= '0;
			h0_q   <= '0;
			h1_q   <= '0;
			nsl_q  <= '0;
			shb_q  <= '0;
		end else if (fire) begin
			mode_q <= mode_n;
			off_q  <= off_n;
			rem_q  <= rem_n;
			h0_q   <= h0_n;
			h1_q   <= h1_n;
			nsl_q  <= nsl_n;
			shb_q  <= shb_n;
		end
	end

endmodule

FILE: sv/hrd_outbuf.sv
// Result buffer: holds one run of result words and shifts them out one per cycle while out_stall is low.
module hrd_outbuf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  hrd_pkg::run_t    run,
	input  logic             out_stall,
	output logic             in_stall,
	output logic             out_valid,
	output hrd_pkg::result_t head
);

	hrd_pkg::result_t [hrd_pkg::RunMax-1:0] ent_q;
	logic [hrd_pkg::CntW-1:0]               cnt_q;
	logic                                   take;
	logic                                   load;

	assign out_valid = (cnt_q != '0);
	assign take      = out_valid && !out_stall;
	assign head      = ent_q[0];
	// Take a new word when the buffer is empty or its last word leaves now
	assign in_stall  = !((cnt_q == '0) || (cnt_q == hrd_pkg::CntW'(1) && take));
	assign load      = fire && (run.cnt != '0);

	// Track how many words of the run are left
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= run.cnt;
		end else if (take) begin
			cnt_q <= cnt_q - hrd_pkg::CntW'(1);
		end
	end

	// Load a fresh run or shift the next word to the head
	always_ff @(posedge clk) begin
		if (load) begin
			ent_q <= run.ent;
		end else if (take) begin
			for (int i = 0; i < hrd_pkg::RunMax - 1; i++) begin
				ent_q[i] <= ent_q[i+1];
			end
			ent_q[hrd_pkg::RunMax-1] <= '0;
		end
	end

endmodule

FILE: sv/h265_rtp_depacketizer.sv
// The first result word of a byte appears in the cycle after the byte is accepted.
// Throughput: one result word per cycle (single output port) while out_stall is low;
// a byte causing k words, k at most 7 (start code, rebuilt FU header, frame close), holds
// off the next byte until all have left; a byte of one or no word is taken every cycle.
// Reset (arst_n low): parser idle, counters and held headers cleared, buffer empty.
module h265_rtp_depacketizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        first_of_packet,
	input  logic [15:0] packet_length,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        byte_valid,
	output logic        frame_end,
	output logic        length_error,
	output logic        last_of_run
);

	logic             fire;
	hrd_pkg::run_t    run;
	hrd_pkg::result_t head;

	assign fire = in_valid && !in_stall;

	// Parse the accepted word into a run of result words
	hrd_parse u_parse (
		.clk             (clk),
		.arst_n          (arst_n),
		.fire            (fire),
		.data_byte       (data_byte),
		.first_of_packet (first_of_packet),
		.packet_length   (packet_length),
		.run             (run)
	);

	// Hold the run and hand it out one word at a time
	hrd_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.run       (run),
		.out_stall (out_stall),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.head      (head)
	);

	assign out_byte     = head.out_byte;
	assign byte_valid   = head.byte_valid;
	assign frame_end    = head.frame_end;
	assign length_error = head.length_error;
	assign last_of_run  = head.last_of_run;

endmodule

FILE: sv/hrd_checker.sv
// Port-level checker for the depacketizer, bound to the top level.
`include "h265_rtp_depacketizer_defines.svh"

module hrd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [7:0]  data_byte,
	input logic        first_of_packet,
	input logic [15:0] packet_length,
	input logic        out_valid,
	input logic        out_stall,
	input logic [7:0]  out_byte,
	input logic        byte_valid,
	input logic        frame_end,
	input logic        length_error,
	input logic        last_of_run
);

	// A stalled result word holds
	`HRD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(last_of_run), "stalled result word changed")

	// Marker-only words carry a zero byte
	`HRD_ASSERT_NOW(a_marker_zero, out_valid && !byte_valid, out_byte == 8'h00 && (frame_end || length_error), "marker word malformed")

	// A length error ends the run on its own marker word
	`HRD_ASSERT_NOW(a_err_last, out_valid && length_error, !byte_valid && !frame_end && last_of_run, "length error word malformed")

	// A frame end never rides on a data word
	`HRD_ASSERT_NOW(a_fend_marker, out_valid && frame_end, !byte_valid, "frame end on data word")

	// A new byte is taken only as the last word of the current run leaves
	`HRD_ASSERT_NOW(a_accept_gap, in_valid && !in_stall && out_valid, last_of_run && !out_stall, "byte accepted with run pending")

endmodule

bind h265_rtp_depacketizer hrd_checker u_hrd_checker (.*);
